// File: rtl/dtp_pkg.sv
`default_nettype none

package dtp_pkg;

    localparam int NUM_FIELDS = 6;

    localparam logic [13:0] RUN_MAX       = 14'd9999;
    localparam logic [13:0] FALLBACK_YEAR = 14'd1971;
    localparam logic [13:0] HOUR_MAX      = 14'd23;
    localparam logic [13:0] MINUTE_MAX    = 14'd59;
    localparam logic [13:0] SECOND_MAX    = 14'd59;
    localparam logic [13:0] MONTH_MAX     = 14'd12;
    localparam logic [13:0] FEBRUARY      = 14'd2;

    // 9999 mod 25, residue of a saturated run
    localparam logic [4:0] RUN_MAX_MOD25 = 5'd24;

    typedef logic [13:0] field_t;

    // closed fields of one text, handed from the parser to the checker
    typedef struct packed {
        field_t year;
        field_t month;
        field_t day;
        field_t hour;
        field_t minute;
        field_t second;
        logic   short_seen;
        logic   year_div25;
    } snap_t;

    function automatic logic [4:0] month_len(input logic [3:0] mo, input logic leap);
        logic [4:0] len;
        begin
            case (mo)
                4'd1:    len = 5'd31;
                4'd2:    len = leap ? 5'd29 : 5'd28;
                4'd3:    len = 5'd31;
                4'd4:    len = 5'd30;
                4'd5:    len = 5'd31;
                4'd6:    len = 5'd30;
                4'd7:    len = 5'd31;
                4'd8:    len = 5'd31;
                4'd9:    len = 5'd30;
                4'd10:   len = 5'd31;
                4'd11:   len = 5'd30;
                4'd12:   len = 5'd31;
                default: len = 5'd0;
            endcase
            return len;
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/datetime_text_parse_validate.sv
// Date-time text parser with calendar check.
//
// Input channel (in_valid/in_ready): one ASCII character per word, with
// last_char marking the end of a text. Digit runs fill year, month, day,
// hour, minute, second in order; anything else separates runs.
// Output channel (out_valid/out_ready): one word per text, after its last
// character: the parsed fields, or 1971-01-01 00:00:00 with used_default
// set when the check fails.
//
// Throughput: one character per cycle while in_ready is high. Each character
// goes through an input register, a parse step that updates the run
// accumulator, and, for the last character, a snapshot register and the
// check logic into the output register.
// A stalled receiver holds the output word; the snapshot and input stages
// keep filling, and in_ready drops only once a finished text cannot move on.
// Non-final characters keep parsing during an output stall.
// Reset (rst_n, asynchronous) empties the pipeline and clears the parse
// state, so the first character after reset starts a new text.

`default_nettype none

module datetime_text_parse_validate
    import dtp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  char_code,
    input  wire logic        last_char,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [13:0]      year_out,
    output logic [3:0]       month_out,
    output logic [4:0]       day_out,
    output logic [4:0]       hour_out,
    output logic [5:0]       minute_out,
    output logic [5:0]       second_out,
    output logic             used_default
);

    logic        s1_valid_reg;
    logic [7:0]  s1_char_reg;
    logic        s1_last_reg;
    logic        snap_valid_reg;
    snap_t       snap_reg;
    logic        out_valid_reg;
    logic [13:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;
    logic [4:0]  hour_reg;
    logic [5:0]  minute_reg;
    logic [5:0]  second_reg;
    logic        dflt_reg;

    logic        out_free;
    logic        snap_free;
    logic        s1_move;
    snap_t       snap_next;
    logic [13:0] year_next;
    logic [3:0]  month_next;
    logic [4:0]  day_next;
    logic [4:0]  hour_next;
    logic [5:0]  minute_next;
    logic [5:0]  second_next;
    logic        dflt_next;

    assign out_free  = !out_valid_reg || out_ready;
    assign snap_free = !snap_valid_reg || out_free;
    // only the final character needs room downstream
    assign s1_move   = s1_valid_reg && (!s1_last_reg || snap_free);
    assign in_ready  = !s1_valid_reg || s1_move;

    dtp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (s1_move),
        .char_code (s1_char_reg),
        .last_char (s1_last_reg),
        .snap      (snap_next)
    );

    dtp_check u_check (
        .snap         (snap_reg),
        .year_out     (year_next),
        .month_out    (month_next),
        .day_out      (day_next),
        .hour_out     (hour_next),
        .minute_out   (minute_next),
        .second_out   (second_next),
        .used_default (dflt_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            snap_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (snap_free)
            begin
                snap_valid_reg <= s1_move && s1_last_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= snap_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_char_reg <= char_code;
            s1_last_reg <= last_char;
        end
        if (snap_free && s1_move && s1_last_reg)
        begin
            snap_reg <= snap_next;
        end
        if (out_free && snap_valid_reg)
        begin
            year_reg   <= year_next;
            month_reg  <= month_next;
            day_reg    <= day_next;
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            second_reg <= second_next;
            dflt_reg   <= dflt_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign year_out     = year_reg;
    assign month_out    = month_reg;
    assign day_out      = day_reg;
    assign hour_out     = hour_reg;
    assign minute_out   = minute_reg;
    assign second_out   = second_reg;
    assign used_default = dflt_reg;

    a_fallback_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && used_default |->
            year_out == FALLBACK_YEAR && month_out == 4'd1 && day_out == 5'd1
            && hour_out == 5'd0 && minute_out == 6'd0 && second_out == 6'd0)
        else $error("fallback word carries parsed fields");

    a_parsed_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !used_default |->
            month_out >= 4'd1 && month_out <= 4'd12 && day_out >= 5'd1
            && hour_out <= 5'd23 && minute_out <= 6'd59 && second_out <= 6'd59)
        else $error("parsed word out of range");

    a_february_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !used_default && month_out == 4'd2 |-> day_out <= 5'd29)
        else $error("February day beyond 29");

endmodule

`default_nettype wire

// File: rtl/dtp_parse.sv
`default_nettype none

module dtp_parse
    import dtp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] char_code,
    input  wire logic       last_char,
    output snap_t           snap
);

    logic [13:0] run_value_reg;
    logic [1:0]  run_digits_reg;
    logic [4:0]  run_mod_reg;
    logic [2:0]  field_index_reg;
    field_t      field_reg [NUM_FIELDS];
    logic        short_reg;
    logic        div25_reg;

    logic [13:0] run_value_next;
    logic [1:0]  run_digits_next;
    logic [4:0]  run_mod_next;
    logic [2:0]  field_index_next;
    field_t      field_next [NUM_FIELDS];
    logic        short_next;
    logic        div25_next;

    logic        is_digit;
    logic [3:0]  digit;
    logic [17:0] acc_sum;
    logic        acc_sat;
    logic [13:0] upd_value;
    logic [1:0]  upd_digits;
    logic [7:0]  mod_sum;
    logic [15:0] mod_prod;
    logic [3:0]  mod_q;
    logic [7:0]  mod_q25;
    logic [4:0]  upd_mod;
    logic [13:0] src_value;
    logic [1:0]  src_digits;
    logic [4:0]  src_mod;
    logic        do_close;
    logic        store;

    always_comb
    begin
        is_digit = (char_code >= 8'h30) && (char_code <= 8'h39);
        digit    = is_digit ? char_code[3:0] : 4'd0;

        acc_sum   = 18'(run_value_reg) * 18'd10 + 18'(digit);
        acc_sat   = acc_sum > 18'(RUN_MAX);
        upd_value = acc_sat ? RUN_MAX : acc_sum[13:0];
        upd_digits = (run_digits_reg == 2'd3) ? 2'd3 : run_digits_reg + 2'd1;

        // run value mod 25 kept alongside, for the century leap test
        mod_sum  = 8'(run_mod_reg) * 8'd10 + 8'(digit);
        mod_prod = 16'(mod_sum) * 16'd41;
        mod_q    = mod_prod[13:10];
        mod_q25  = 8'(mod_q) * 8'd25;
        upd_mod  = acc_sat ? RUN_MAX_MOD25 : 5'(mod_sum - mod_q25);

        src_value  = is_digit ? upd_value  : run_value_reg;
        src_digits = is_digit ? upd_digits : run_digits_reg;
        src_mod    = is_digit ? upd_mod    : run_mod_reg;

        do_close = !is_digit || last_char;
        store    = do_close && (src_digits != 2'd0)
                   && (field_index_reg < 3'(NUM_FIELDS));

        for (int i = 0; i < NUM_FIELDS; i++)
        begin
            field_next[i] = (store && (field_index_reg == 3'(i))) ? src_value : field_reg[i];
        end
        short_next = short_reg
                     | (store && (field_index_reg == 3'd1 || field_index_reg == 3'd2)
                        && (src_digits < 2'd2));
        div25_next = (store && (field_index_reg == 3'd0)) ? (src_mod == 5'd0) : div25_reg;
        field_index_next = store ? field_index_reg + 3'd1 : field_index_reg;

        run_value_next  = do_close ? 14'd0 : upd_value;
        run_digits_next = do_close ? 2'd0  : upd_digits;
        run_mod_next    = do_close ? 5'd0  : upd_mod;

        snap.year       = field_next[0];
        snap.month      = field_next[1];
        snap.day        = field_next[2];
        snap.hour       = field_next[3];
        snap.minute     = field_next[4];
        snap.second     = field_next[5];
        snap.short_seen = short_next;
        snap.year_div25 = div25_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_value_reg   <= '0;
            run_digits_reg  <= '0;
            run_mod_reg     <= '0;
            field_index_reg <= '0;
            short_reg       <= 1'b0;
            div25_reg       <= 1'b1;
            for (int i = 0; i < NUM_FIELDS; i++)
            begin
                field_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            if (last_char)
            begin
                // text done: start the next one clean
                run_value_reg   <= '0;
                run_digits_reg  <= '0;
                run_mod_reg     <= '0;
                field_index_reg <= '0;
                short_reg       <= 1'b0;
                div25_reg       <= 1'b1;
                for (int i = 0; i < NUM_FIELDS; i++)
                begin
                    field_reg[i] <= '0;
                end
            end
            else
            begin
                run_value_reg   <= run_value_next;
                run_digits_reg  <= run_digits_next;
                run_mod_reg     <= run_mod_next;
                field_index_reg <= field_index_next;
                short_reg       <= short_next;
                div25_reg       <= div25_next;
                for (int i = 0; i < NUM_FIELDS; i++)
                begin
                    field_reg[i] <= field_next[i];
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/dtp_check.sv
`default_nettype none

module dtp_check
    import dtp_pkg::*;
(
    input  wire snap_t        snap,
    output logic [13:0]       year_out,
    output logic [3:0]        month_out,
    output logic [4:0]        day_out,
    output logic [4:0]        hour_out,
    output logic [5:0]        minute_out,
    output logic [5:0]        second_out,
    output logic              used_default
);

    logic       leap;
    logic [4:0] len;
    logic       month_ok;
    logic       time_ok;
    logic       day_ok;
    logic       ok;

    always_comb
    begin
        // divisible by 4 but not 100, or by 400 (16 and 25)
        leap = ((snap.year[1:0] == 2'd0) && !snap.year_div25)
               || ((snap.year[3:0] == 4'd0) && snap.year_div25);
        month_ok = (snap.month != 14'd0) && (snap.month <= MONTH_MAX);
        len      = month_len(snap.month[3:0], leap && (snap.month == FEBRUARY));
        time_ok  = (snap.hour <= HOUR_MAX) && (snap.minute <= MINUTE_MAX)
                   && (snap.second <= SECOND_MAX);
        day_ok   = (snap.day != 14'd0) && (snap.day <= 14'(len));
        ok       = month_ok && time_ok && day_ok && !snap.short_seen;

        if (ok)
        begin
            year_out     = snap.year;
            month_out    = snap.month[3:0];
            day_out      = snap.day[4:0];
            hour_out     = snap.hour[4:0];
            minute_out   = snap.minute[5:0];
            second_out   = snap.second[5:0];
            used_default = 1'b0;
        end
        else
        begin
            year_out     = FALLBACK_YEAR;
            month_out    = 4'd1;
            day_out      = 5'd1;
            hour_out     = 5'd0;
            minute_out   = 6'd0;
            second_out   = 6'd0;
            used_default = 1'b1;
        end
    end

endmodule

`default_nettype wire
